// ===== rtl/qa_pkg.sv =====
// Shared types and constants for the quadrilateral area core.
// No dependencies.
package qa_pkg;
    localparam int COORD_WIDTH = 20;
    localparam int AREA_WIDTH  = 2 * COORD_WIDTH + 3;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int NUM_CELLS   = 4;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [CROSS_WIDTH-1:0] cross_t;

    typedef struct packed {
        coord_t ax; coord_t ay; coord_t bx; coord_t by;
        coord_t cx; coord_t cy; coord_t dx; coord_t dy;
    } corners_t;

    // Cross products carried down the chain.
    typedef struct packed {
        cross_t s_b;
        cross_t s_d;
        cross_t s_a;
        cross_t s_c;
        cross_t cr;
    } cross_set_t;

    typedef logic [AREA_WIDTH-1:0] area_t;
endpackage

// ===== rtl/qa_cell.sv =====
// One stage of the area chain; holds a valid bit and a payload word.
// Depends on qa_pkg. Stage behavior is chosen by the STAGE input.
module qa_cell
    import qa_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] stage,
    input  logic       advance,
    input  logic       in_valid,
    input  corners_t   in_corners,
    input  cross_set_t in_cross,
    input  logic       in_dart,
    input  area_t      in_area,
    output logic       out_valid,
    output corners_t   out_corners,
    output cross_set_t out_cross,
    output logic       out_dart,
    output area_t      out_area
);
    localparam logic [1:0] STG_DIFF = 2'd0;
    localparam logic [1:0] STG_MUL  = 2'd1;
    localparam logic [1:0] STG_SUB  = 2'd2;
    localparam logic [1:0] STG_SEL  = 2'd3;

    logic       valid_reg;
    corners_t   corners_reg, corners_next;
    cross_set_t cross_reg, cross_next;
    logic       dart_reg, dart_next;
    area_t      area_reg, area_next;

    function automatic diff_t df(coord_t p, coord_t q);
        return diff_t'(p) - diff_t'(q);
    endfunction

    function automatic cross_t cabs(cross_t v);
        return v[CROSS_WIDTH-1] ? -v : v;
    endfunction

    function automatic logic sgn_same(cross_t s, cross_t t);
        logic sz, tz;
        sz = (s == '0);
        tz = (t == '0);
        return !sz && !tz && (s[CROSS_WIDTH-1] == t[CROSS_WIDTH-1]);
    endfunction

    always_comb
    begin
        diff_t d0, d1, d2, d3, d4, d5, d6, d7;
        diff_t e0, e1, e2, e3, e4, e5, e6, e7, e8, e9;
        cross_t t1, t2, tdiff;
        logic ac_side, dart;
        corners_next = in_corners;
        cross_next   = in_cross;
        dart_next    = in_dart;
        area_next    = in_area;
        d0 = '0; d1 = '0; d2 = '0; d3 = '0; d4 = '0; d5 = '0; d6 = '0; d7 = '0;
        e0 = '0; e1 = '0; e2 = '0; e3 = '0; e4 = '0; e5 = '0; e6 = '0; e7 = '0;
        e8 = '0; e9 = '0;
        t1 = '0; t2 = '0; tdiff = '0; ac_side = 1'b0; dart = 1'b0;
        unique case (stage)
            STG_DIFF:
            begin
                // Hold differences in the cross fields as packed pairs of sign-extended values.
                d0 = df(in_corners.bx, in_corners.ax);
                d1 = df(in_corners.cy, in_corners.ay);
                d2 = df(in_corners.by, in_corners.ay);
                d3 = df(in_corners.cx, in_corners.ax);
                d4 = df(in_corners.dx, in_corners.ax);
                d5 = df(in_corners.dy, in_corners.ay);
                cross_next.s_b = cross_t'({d0, d1});
                cross_next.s_d = cross_t'({d2, d3});
                cross_next.s_a = cross_t'({d4, d5});
                d6 = df(in_corners.dx, in_corners.bx);
                d7 = df(in_corners.dy, in_corners.by);
                cross_next.s_c = cross_t'({d6, d7});
                cross_next.cr  = '0;
            end
            STG_MUL:
            begin
                e0 = diff_t'(in_cross.s_b[PROD_WIDTH-1:DIFF_WIDTH]); // bx-ax
                e1 = diff_t'(in_cross.s_b[DIFF_WIDTH-1:0]);          // cy-ay
                e2 = diff_t'(in_cross.s_d[PROD_WIDTH-1:DIFF_WIDTH]); // by-ay
                e3 = diff_t'(in_cross.s_d[DIFF_WIDTH-1:0]);          // cx-ax
                e4 = diff_t'(in_cross.s_a[PROD_WIDTH-1:DIFF_WIDTH]); // dx-ax
                e5 = diff_t'(in_cross.s_a[DIFF_WIDTH-1:0]);          // dy-ay
                e6 = diff_t'(in_cross.s_c[PROD_WIDTH-1:DIFF_WIDTH]); // dx-bx
                e7 = diff_t'(in_cross.s_c[DIFF_WIDTH-1:0]);          // dy-by
                e8 = df(in_corners.ax, in_corners.bx);
                e9 = df(in_corners.ay, in_corners.by);
                // s_b = e0*e1 - e2*e3; s_d = e4*e1 - e5*e3
                // s_a = e8*e7 - e9*e6; s_c = (cx-bx)*e7 - (cy-by)*e6
                // cr = e3*e7 - e1*e6 ; store products, subtract next stage
                cross_next.s_b = cross_t'(prod_t'(e0 * e1));
                cross_next.s_d = cross_t'(prod_t'(e4 * e1));
                cross_next.s_a = cross_t'(prod_t'(e8 * e7));
                cross_next.s_c = cross_t'(prod_t'(df(in_corners.cx, in_corners.bx) * e7));
                cross_next.cr  = cross_t'(prod_t'(e3 * e7));
                area_next = '0;
            end
            STG_SUB:
            begin
                e1 = df(in_corners.cy, in_corners.ay);
                e2 = df(in_corners.by, in_corners.ay);
                e3 = df(in_corners.cx, in_corners.ax);
                e5 = df(in_corners.dy, in_corners.ay);
                e6 = df(in_corners.dx, in_corners.bx);
                e9 = df(in_corners.ay, in_corners.by);
                cross_next.s_b = in_cross.s_b - cross_t'(prod_t'(e2 * e3));
                cross_next.s_d = in_cross.s_d - cross_t'(prod_t'(e5 * e3));
                cross_next.s_a = in_cross.s_a - cross_t'(prod_t'(e9 * e6));
                cross_next.s_c = in_cross.s_c
                    - cross_t'(prod_t'(df(in_corners.cy, in_corners.by) * e6));
                cross_next.cr  = in_cross.cr - cross_t'(prod_t'(e1 * e6));
            end
            STG_SEL:
            begin
                ac_side = sgn_same(in_cross.s_b, in_cross.s_d);
                dart    = ac_side || sgn_same(in_cross.s_a, in_cross.s_c);
                t1      = cabs(in_cross.s_b);
                t2      = cabs(in_cross.s_d);
                tdiff   = t1 - t2;
                dart_next = dart;
                if (!dart)
                    area_next = area_t'({cabs(in_cross.cr), 1'b0});
                else if (ac_side)
                    area_next = area_t'({cabs(tdiff), 1'b0});
                else
                    area_next = area_t'({t1 + t2, 1'b0});
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            corners_reg <= corners_next;
            cross_reg   <= cross_next;
            dart_reg    <= dart_next;
            area_reg    <= area_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_corners = corners_reg;
    assign out_cross   = cross_reg;
    assign out_dart    = dart_reg;
    assign out_area    = area_reg;
endmodule

// ===== rtl/quadrilateral_area_core.sv =====
// Quadrilateral area core: four-cell chain computing floor(4 * area).
// Cells DIFF, MUL, SUB, SEL in order; one request per cycle unless stalled.
// The chain stalls as a whole only when the last cell holds an untaken result.
// rst_n clears all valid bits asynchronously; payload is not reset.
// Depends on qa_pkg and qa_cell.
module quadrilateral_area_core
    import qa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COORD_WIDTH-1:0] corner1_x,
    input  logic [COORD_WIDTH-1:0] corner1_y,
    input  logic [COORD_WIDTH-1:0] corner2_x,
    input  logic [COORD_WIDTH-1:0] corner2_y,
    input  logic [COORD_WIDTH-1:0] corner3_x,
    input  logic [COORD_WIDTH-1:0] corner3_y,
    input  logic [COORD_WIDTH-1:0] corner4_x,
    input  logic [COORD_WIDTH-1:0] corner4_y,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [AREA_WIDTH-1:0] area_times_four,
    output logic                  dart_found
);
    logic       v   [NUM_CELLS+1];
    corners_t   c   [NUM_CELLS+1];
    cross_set_t x   [NUM_CELLS+1];
    logic       d   [NUM_CELLS+1];
    area_t      a   [NUM_CELLS+1];
    logic       advance;

    // Advance the chain unless the final result is held.
    assign advance  = !(v[NUM_CELLS] && out_stall);
    assign in_stall = !advance;

    assign v[0] = in_valid;
    assign c[0] = '{ax: corner1_x, ay: corner1_y, bx: corner2_x, by: corner2_y,
                    cx: corner3_x, cy: corner3_y, dx: corner4_x, dy: corner4_y};
    assign x[0] = '0;
    assign d[0] = 1'b0;
    assign a[0] = '0;

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        qa_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .stage       (2'(i)),
            .advance     (advance),
            .in_valid    (v[i]),
            .in_corners  (c[i]),
            .in_cross    (x[i]),
            .in_dart     (d[i]),
            .in_area     (a[i]),
            .out_valid   (v[i+1]),
            .out_corners (c[i+1]),
            .out_cross   (x[i+1]),
            .out_dart    (d[i+1]),
            .out_area    (a[i+1])
        );
    end

    assign out_valid       = v[NUM_CELLS];
    assign area_times_four = a[NUM_CELLS];
    assign dart_found      = d[NUM_CELLS];

`ifndef NO_ASSERTIONS
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(area_times_four))
        else $error("result changed while held");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without held result");
    a_area_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !area_times_four[0])
        else $error("odd area result");
`endif
endmodule
